@@ sv/pmmu_pkg.sv @@
package pmmu_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_PROCS_DEF      = 64;
    localparam int PAGES_PER_PROC_DEF = 32;

    // Fixed geometry
    localparam int NUM_FRAMES     = 32;
    localparam int RESERVED_PAGES = 3;
    localparam int OS_FRAMES      = 3;
    localparam int PAGE_WORDS     = 2048;

    localparam int VA_W    = 16;
    localparam int OFF_W   = $clog2(PAGE_WORDS);
    localparam int VPN_W   = VA_W - OFF_W;
    localparam int CMD_W   = 3;
    localparam int PID_W   = 6;
    localparam int ST_W    = 3;
    localparam int FRAME_W = 5;
    localparam int CNT_W   = 6;
    localparam int PTE_W   = 8;
    localparam int BMAP_W  = 32;
    localparam int Q_DEPTH = 2;
    localparam int QC_W    = 2;

    // Frame bitmap masks
    localparam logic [BMAP_W-1:0] FRAME_MASK = (NUM_FRAMES >= BMAP_W) ? {BMAP_W{1'b1}} :
        BMAP_W'((64'd1 << NUM_FRAMES) - 64'd1);
    localparam logic [BMAP_W-1:0] FREE_RESET = FRAME_MASK &
        ~BMAP_W'((64'd1 << OS_FRAMES) - 64'd1);

    // Page table entry layout
    localparam int PTE_VALID_BIT = 0;
    localparam int PTE_READ_BIT  = 1;
    localparam int PTE_WRITE_BIT = 2;
    localparam int PTE_FRAME_LSB = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_RESERVED  = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_VALID = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_READ   = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_WRITE  = 3'd4;
    localparam logic [ST_W-1:0] ST_ALREADY   = 3'd5;
    localparam logic [ST_W-1:0] ST_NO_FRAME  = 3'd6;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_ALLOC,
        OP_FREE,
        OP_RELEASE,
        OP_RESERVED,
        OP_IGNORE
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] proc_id;
        logic [VA_W-1:0]  vaddr;
        logic             allow_read;
        logic             allow_write;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VA_W-1:0]    paddr;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   freed_count;
    } t_out_item;

    // Classified command handed from front to back
    typedef struct packed {
        t_op              op;
        logic [OFF_W-1:0] off;
        logic             allow_read;
        logic             allow_write;
    } t_job;

endpackage

@@ sv/pmmu_front.sv @@
module pmmu_front import pmmu_pkg::*; #(
    parameter int NUM_PROCS      = NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = PAGES_PER_PROC_DEF,
    localparam int SLOT_W        = $clog2(NUM_PROCS * PAGES_PER_PROC),
    localparam int PG_W          = $clog2(PAGES_PER_PROC),
    localparam int PIDX_W        = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in,
    input  logic              i_ready,
    output logic              o_q_valid,
    output t_job              o_q_job,
    output logic [SLOT_W-1:0] o_q_slot,
    input  logic              i_q_pop
);

    logic [PIDX_W-1:0] pid_tab [2**PID_W];
    logic [VPN_W-1:0]  vpn;
    logic              rsv;
    logic [PG_W-1:0]   pg_sel;
    logic [31:0]       base_full;
    logic [SLOT_W-1:0] slot;
    t_job              job;
    logic              push;

    t_job              r_q_job  [Q_DEPTH];
    logic [SLOT_W-1:0] r_q_slot [Q_DEPTH];
    logic              r_wp, n_wp;
    logic              r_rp, n_rp;
    logic [QC_W-1:0]   r_q_cnt, n_q_cnt;

    // Fold the process number into range
    for (genvar g = 0; g < 2**PID_W; g++) begin : g_pid
        assign pid_tab[g] = PIDX_W'(g % NUM_PROCS);
    end

    // Classify the incoming item
    assign vpn = i_in.vaddr[VA_W-1:OFF_W];
    assign rsv = (32'(vpn) < RESERVED_PAGES) || (32'(vpn) >= PAGES_PER_PROC);

    always_comb begin
        job.off         = i_in.vaddr[OFF_W-1:0];
        job.allow_read  = i_in.allow_read;
        job.allow_write = i_in.allow_write;
        unique case (i_in.cmd)
            CMD_READ:    job.op = rsv ? OP_RESERVED : OP_READ;
            CMD_WRITE:   job.op = rsv ? OP_RESERVED : OP_WRITE;
            CMD_ALLOC:   job.op = rsv ? OP_RESERVED : OP_ALLOC;
            CMD_FREE:    job.op = rsv ? OP_RESERVED : OP_FREE;
            CMD_RELEASE: job.op = OP_RELEASE;
            default:     job.op = OP_IGNORE;
        endcase
    end

    // Table slot; release starts at the process base
    assign pg_sel    = (job.op == OP_RELEASE) ? '0 : PG_W'(vpn);
    assign base_full = 32'(pid_tab[i_in.proc_id]) * 32'(PAGES_PER_PROC);
    assign slot      = SLOT_W'(base_full) + SLOT_W'(pg_sel);

    // Queue toward the back end
    assign o_in_stall = (r_q_cnt == QC_W'(Q_DEPTH)) || !i_ready;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_q_cnt != '0);
    assign o_q_job    = r_q_job[r_rp];
    assign o_q_slot   = r_q_slot[r_rp];

    assign n_wp    = push ? ~r_wp : r_wp;
    assign n_rp    = i_q_pop ? ~r_rp : r_rp;
    assign n_q_cnt = r_q_cnt + QC_W'(push) - QC_W'(i_q_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_q_cnt <= n_q_cnt;
        end
    end

    // Store the queued item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_job[r_wp]  <= job;
            r_q_slot[r_wp] <= slot;
        end
    end

endmodule

@@ sv/pmmu_back.sv @@
module pmmu_back import pmmu_pkg::*; #(
    parameter int NUM_PROCS      = NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = PAGES_PER_PROC_DEF,
    localparam int DEPTH         = NUM_PROCS * PAGES_PER_PROC,
    localparam int SLOT_W        = $clog2(DEPTH),
    localparam int PG_W          = $clog2(PAGES_PER_PROC)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_job              i_q_job,
    input  logic [SLOT_W-1:0] i_q_slot,
    output logic              o_q_pop,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out
);

    logic [PTE_W-1:0]   mem [DEPTH];
    logic [PTE_W-1:0]   r_rd_data;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_clr, n_clr;
    t_job               r_job, n_job;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [PG_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BMAP_W-1:0]  r_free, n_free;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_wa;
    logic [PTE_W-1:0]   mem_wd;
    logic               mem_re;
    logic [SLOT_W-1:0]  mem_ra;
    logic               load_out;
    t_out_item          res;
    logic               out_free;
    logic               walk_last;

    logic               pte_v, pte_r, pte_w;
    logic [FRAME_W-1:0] pte_f;
    logic [BMAP_W-1:0]  avail;
    logic [FRAME_W-1:0] low_f;
    logic [SLOT_W-1:0]  walk_addr;

    // Entry fields of the word just read
    assign pte_v = r_rd_data[PTE_VALID_BIT];
    assign pte_r = r_rd_data[PTE_READ_BIT];
    assign pte_w = r_rd_data[PTE_WRITE_BIT];
    assign pte_f = r_rd_data[PTE_FRAME_LSB +: FRAME_W];

    assign out_free  = !r_out_valid || !i_out_stall;
    assign walk_last = (r_idx == PG_W'(PAGES_PER_PROC - 1));
    assign walk_addr = r_slot + SLOT_W'(r_idx);
    assign avail     = r_free & FRAME_MASK;
    assign o_ready   = (r_state != S_CLEAR);

    // Find the lowest free frame
    always_comb begin
        low_f = '0;
        for (int k = BMAP_W - 1; k >= 0; k--) begin
            if (avail[k]) begin
                low_f = FRAME_W'(k);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == SLOT_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_job.op == OP_RELEASE) ? S_WALK : S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Datapath control per state
    always_comb begin
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra   = '0;
        load_out = 1'b0;
        res      = '0;
        n_clr    = r_clr;
        n_job    = r_job;
        n_slot   = r_slot;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_free   = r_free;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + SLOT_W'(1);
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    mem_re  = 1'b1;
                    mem_ra  = i_q_slot;
                    n_job   = i_q_job;
                    n_slot  = i_q_slot;
                    n_idx   = '0;
                    n_cnt   = '0;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    unique case (r_job.op)
                        OP_READ, OP_WRITE: begin
                            if (!pte_v) begin
                                res.status = ST_NOT_VALID;
                            end else if (r_job.op == OP_READ && !pte_r) begin
                                res.status = ST_NO_READ;
                            end else if (r_job.op == OP_WRITE && !pte_w) begin
                                res.status = ST_NO_WRITE;
                            end else begin
                                res.paddr = VA_W'({pte_f, r_job.off});
                            end
                        end
                        OP_ALLOC: begin
                            if (pte_v) begin
                                res.status = ST_ALREADY;
                            end else if (avail == '0) begin
                                res.status = ST_NO_FRAME;
                            end else begin
                                res.frame = low_f;
                                n_free    = r_free & ~(BMAP_W'(1) << low_f);
                                mem_we    = 1'b1;
                                mem_wa    = r_slot;
                                mem_wd    = PTE_W'({low_f, r_job.allow_write,
                                                    r_job.allow_read, 1'b1});
                            end
                        end
                        OP_FREE: begin
                            if (!pte_v) begin
                                res.status = ST_NOT_VALID;
                            end else begin
                                res.frame = pte_f;
                                n_free    = r_free | ((BMAP_W'(1) << pte_f) & FRAME_MASK);
                                mem_we    = 1'b1;
                                mem_wa    = r_slot;
                                mem_wd    = r_rd_data & ~PTE_W'(1 << PTE_VALID_BIT);
                            end
                        end
                        OP_RESERVED: begin
                            res.status = ST_RESERVED;
                        end
                        default: begin
                            res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Free this entry if valid, fetch the next
                if (pte_v) begin
                    n_free = r_free | ((BMAP_W'(1) << pte_f) & FRAME_MASK);
                    n_cnt  = r_cnt + CNT_W'(1);
                    mem_we = 1'b1;
                    mem_wa = walk_addr;
                    mem_wd = r_rd_data & ~PTE_W'(1 << PTE_VALID_BIT);
                end
                if (!walk_last) begin
                    mem_re = 1'b1;
                    mem_ra = walk_addr + SLOT_W'(1);
                    n_idx  = r_idx + PG_W'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    res.status      = ST_OK;
                    res.freed_count = r_cnt;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_free      <= FREE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_free      <= n_free;
            r_out_valid <= load_out ? 1'b1 : (r_out_valid && i_out_stall);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_slot <= n_slot;
        if (load_out) begin
            r_out <= res;
        end
    end

    // Page table store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/paged_mmu_with_frame_allocator_unit.sv @@
// Every command but release: the back end reads the table entry, then executes and
// registers the result; release walks the process's PAGES_PER_PROC entries
// (one table entry per cycle), then gives the freed count. The back end takes no new item
// until the last one's result is loaded. A two-entry queue sits between front and back.
// Reset (synchronous, active low) clears all NUM_PROCS * PAGES_PER_PROC table entries
// (2048 by default) with the input stalled; frames 0 to 2 start used.
module paged_mmu_with_frame_allocator_unit import pmmu_pkg::*; #(
    parameter int NUM_PROCS      = NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = PAGES_PER_PROC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int SLOT_W = $clog2(NUM_PROCS * PAGES_PER_PROC);

    logic              q_valid;
    t_job              q_job;
    logic [SLOT_W-1:0] q_slot;
    logic              q_pop;
    logic              ready;

    // Accept and classify
    pmmu_front #(
        .NUM_PROCS      (NUM_PROCS),
        .PAGES_PER_PROC (PAGES_PER_PROC)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_ready    (ready),
        .o_q_valid  (q_valid),
        .o_q_job    (q_job),
        .o_q_slot   (q_slot),
        .i_q_pop    (q_pop)
    );

    // Execute against the page table and frame bitmap
    pmmu_back #(
        .NUM_PROCS      (NUM_PROCS),
        .PAGES_PER_PROC (PAGES_PER_PROC)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .i_q_slot    (q_slot),
        .o_q_pop     (q_pop),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
